@@ sv/scfp_pkg.sv @@
// Shared constants, types and helper functions of the stub concentrator frame packer.
package scfp_pkg;

  localparam int NUM_SLOTS = 40;
  localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SIDE_AW   = SLOT_AW + 1;
  localparam int FRM_AW    = SLOT_AW + 3;
  localparam int SIDE_DEPTH = 2 * NUM_SLOTS;
  localparam int FRM_DEPTH  = 8 * NUM_SLOTS;
  localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(NUM_SLOTS - 1);

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int ID_W     = 18;
  localparam int ADDR_W   = 11;
  localparam int BEND_W   = 5;
  localparam int Z_W      = 5;
  localparam int WORD_W   = 64;
  localparam int WIDX_W   = 3;
  localparam int CNT_W    = 4;
  localparam int HWM_W    = 9;
  localparam int SIDE_ST_W = 1 + CNT_W + HWM_W;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_PACK = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam int LAYER_DIV      = 10000;
  localparam int LAYER_2S_ABOVE = 7;
  // id / 10000 > 7  <=>  id >= 80000
  localparam logic [ID_W-1:0] ID_2S_MIN = ID_W'(LAYER_DIV * (LAYER_2S_ABOVE + 1));

  localparam int HDR_BITS = 26;
  localparam logic [CNT_W-1:0] MAX_2S   = 4'd12;
  localparam logic [CNT_W-1:0] MAX_PS   = 4'd10;
  localparam logic [Z_W-1:0]   PS_SPLIT = 5'd16;
  localparam logic [4:0]       SIZE_2S  = 5'd19;
  localparam logic [4:0]       SIZE_PS  = 5'd23;

  localparam logic [WORD_W-1:0] HDR_MASK =
    {{(WORD_W - HDR_BITS){1'b0}}, {HDR_BITS{1'b1}}};

  typedef struct packed {
    logic               rd;
    logic               hi;
    logic               two_s;
    logic [1:0]         widx;
    logic [5:0]         off;
    logic [HWM_W-1:0]   hwm;
    logic [CNT_W-1:0]   cnt;
    logic               ovf;
    logic [ADDR_W-1:0]  stub_addr;
    logic [BEND_W-1:0]  stub_bend;
    logic [Z_W-1:0]     stub_z;
  } mrg_ctl_t;

  function automatic logic [4:0] stub_size(input logic two_s);
    return two_s ? SIZE_2S : SIZE_PS;
  endfunction

  // Bits of frame word widx that lie below the written extent hwm.
  function automatic logic [WORD_W-1:0] below_mask(input logic [HWM_W-1:0] hwm,
                                                   input logic [1:0] widx);
    logic [HWM_W-1:0]  ws;
    logic [HWM_W-1:0]  diff;
    logic [WORD_W-1:0] m;
    ws = {1'b0, widx, 6'd0};
    diff = hwm - ws;
    if (hwm <= ws) begin
      m = '0;
    end else if (diff >= 9'd64) begin
      m = '1;
    end else begin
      m = ~({WORD_W{1'b1}} << diff[5:0]);
    end
    return m;
  endfunction

  function automatic logic [WORD_W-1:0] frame_hdr(input logic ps_type, input logic ovf,
                                                  input logic [CNT_W-1:0] cnt);
    logic [WORD_W-1:0] h;
    h = '0;
    h[0] = ps_type;
    h[9] = ovf;
    h[25:22] = cnt;
    return h;
  endfunction

endpackage

@@ sv/scfp_if.sv @@
// Valid/ready channel interfaces for stub input words and frame output words.
interface scfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [scfp_pkg::OP_W-1:0]     opcode;
  logic [scfp_pkg::SLOT_W-1:0]   slot;
  logic [scfp_pkg::ID_W-1:0]     module_id;
  logic [scfp_pkg::ADDR_W-1:0]   stub_address;
  logic signed [scfp_pkg::BEND_W-1:0] stub_bend;
  logic [scfp_pkg::Z_W-1:0]      stub_z;

  modport source (output valid, opcode, slot, module_id, stub_address, stub_bend, stub_z,
                  input ready);
  modport sink (input valid, opcode, slot, module_id, stub_address, stub_bend, stub_z,
                output ready);
endinterface

interface scfp_out_if;
  logic                          valid;
  logic                          ready;
  logic [scfp_pkg::WORD_W-1:0]   frame_word;
  logic [scfp_pkg::WIDX_W-1:0]   word_index;
  logic                          last;

  modport source (output valid, frame_word, word_index, last, input ready);
  modport sink (input valid, frame_word, word_index, last, output ready);
endinterface

@@ sv/scfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module scfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

@@ sv/scfp_merge.sv @@
// Shared shift-and-merge unit: places a stub into a frame word, or masks a word for readout.
module scfp_merge (
  input  scfp_pkg::mrg_ctl_t           ctl,
  input  logic [scfp_pkg::WORD_W-1:0]  old_word,
  output logic [scfp_pkg::WORD_W-1:0]  new_word
);
  import scfp_pkg::*;

  logic [22:0]         stub;
  logic [22:0]         fld;
  logic [127:0]        sh_d;
  logic [127:0]        sh_m;
  logic [WORD_W-1:0]   part_d;
  logic [WORD_W-1:0]   part_m;
  logic [WORD_W-1:0]   eff;

  always_comb begin
    // bx is always zero; 2S stubs carry no z
    stub = {(ctl.two_s ? 4'd0 : ctl.stub_z[3:0]), ctl.stub_bend, ctl.stub_addr, 3'b000};
    fld  = ctl.two_s ? 23'h07FFFF : 23'h7FFFFF;
    sh_d = {105'd0, stub} << ctl.off;
    sh_m = {105'd0, fld} << ctl.off;
    part_d = ctl.hi ? sh_d[127:64] : sh_d[63:0];
    part_m = ctl.hi ? sh_m[127:64] : sh_m[63:0];
    // anything past the written extent is stale and reads as zero
    eff = old_word & below_mask(ctl.hwm, ctl.widx);
    if (ctl.rd) begin
      if (ctl.widx == 2'd0) begin
        new_word = (eff & ~HDR_MASK) | frame_hdr(~ctl.two_s, ctl.ovf, ctl.cnt);
      end else begin
        new_word = eff;
      end
    end else begin
      new_word = (eff & ~part_m) | part_d;
    end
  end
endmodule

@@ sv/stub_concentrator_frame_packer.sv @@
// Stub concentrator frame packer: slot id table, frame memory and packing sequencer.
//
// Input channel (in_chan): one word per operation. Load writes a slot's module id.
// Pack compares the stub's module id with every slot id, one slot per cycle while
// slots miss, and writes the stub into each matching slot's left or right frame
// (into both frame words when it straddles two 64-bit words), or flags overflow
// when that side is already full. The id scan goes through the single read port
// of the id memory. Readout of a slot emits eight 64-bit words on out_chan, right
// frame then left, high slice first, and clears the slot's frames, counts and
// overflow flags; the words pass one at a time through the frame port.
// in_chan.ready is high only between operations; the last readout word may still
// wait in the output register while the next operation is taken.
// A stalled receiver holds the output register and halts the readout sequencer.
// Reset (rst_n low, synchronous) clears all slot ids, counts and overflow flags
// through per-entry valid bits; no clearing pass is needed and the block is ready
// as soon as reset is released.
module stub_concentrator_frame_packer (
  input  logic        clk,
  input  logic        rst_n,
  scfp_in_if.sink     in_chan,
  scfp_out_if.source  out_chan
);
  import scfp_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PK_ID   = 4'd1;
  localparam logic [3:0] S_PK_CMP  = 4'd2;
  localparam logic [3:0] S_PK_ST   = 4'd3;
  localparam logic [3:0] S_PK_F0   = 4'd4;
  localparam logic [3:0] S_PK_F1   = 4'd5;
  localparam logic [3:0] S_RO_HDR  = 4'd6;
  localparam logic [3:0] S_RO_HDRL = 4'd7;
  localparam logic [3:0] S_RO_RD   = 4'd8;
  localparam logic [3:0] S_RO_OUT  = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [SLOT_AW-1:0]  m_r, m_nxt;
  logic [SLOT_AW-1:0]  slot_r, slot_nxt;
  logic [2:0]          k_r, k_nxt;
  logic                two_s_r, two_s_nxt;
  logic                side_r, side_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [HWM_W-1:0]    hwm_r, hwm_nxt;
  logic [7:0]          base_r, base_nxt;

  logic [ID_W-1:0]          id_r;
  logic [ADDR_W-1:0]        addr_r;
  logic signed [BEND_W-1:0] bend_r;
  logic [Z_W-1:0]           z_r;

  logic [NUM_SLOTS-1:0]  id_vld_r, id_vld_nxt;
  logic [SIDE_DEPTH-1:0] st_vld_r, st_vld_nxt;
  logic                  id_vld_q_r, st_vld_q_r;

  logic                out_valid_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [WIDX_W-1:0]   out_idx_r;
  logic                out_last_r;
  logic                out_load;
  logic                out_free;

  logic                in_acc;
  logic                slot_ok;
  logic [SLOT_AW-1:0]  in_slot;

  logic                id_wr_en, id_rd_en;
  logic [SLOT_AW-1:0]  id_rd_addr;
  logic [ID_W-1:0]     id_rd_data, id_eff;

  logic                 st_wr_en, st_rd_en;
  logic [SIDE_AW-1:0]   st_wr_addr, st_rd_addr;
  logic [SIDE_ST_W-1:0] st_wr_data, st_rd_data, st_eff;

  logic                fr_wr_en, fr_rd_en;
  logic [FRM_AW-1:0]   fr_wr_addr, fr_rd_addr;
  logic [WORD_W-1:0]   fr_rd_data, fr_wr_data;

  logic [4:0]          size;
  logic [HWM_W-1:0]    base_calc;
  logic [HWM_W-1:0]    end_pos;
  logic [HWM_W-1:0]    hwm_new;
  logic                need_hi;
  logic [1:0]          w_lo, w_hi;
  mrg_ctl_t            mctl;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign slot_ok  = ({1'b0, in_chan.slot} < 7'(NUM_SLOTS));
  assign in_slot  = in_chan.slot[SLOT_AW-1:0];
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  assign id_eff = id_vld_q_r ? id_rd_data : '0;
  assign st_eff = st_vld_q_r ? st_rd_data : '0;

  assign size      = stub_size(two_s_r);
  assign base_calc = 9'(HDR_BITS) + 9'({5'd0, st_eff[SIDE_ST_W-2 -: CNT_W]} * {4'd0, size});
  assign end_pos   = {1'b0, base_r} + {4'd0, size};
  assign hwm_new   = (end_pos > hwm_r) ? end_pos : hwm_r;
  assign need_hi   = ({1'b0, base_r[5:0]} + {2'd0, size}) > 7'd64;
  assign w_lo      = base_r[7:6];
  assign w_hi      = base_r[7:6] + 2'd1;

  always_comb begin
    mctl.rd        = (state_r == S_RO_OUT);
    mctl.hi        = (state_r == S_PK_F1);
    mctl.two_s     = two_s_r;
    mctl.widx      = mctl.rd ? ~k_r[1:0] : (mctl.hi ? w_hi : w_lo);
    mctl.off       = base_r[5:0];
    mctl.hwm       = hwm_r;
    mctl.cnt       = cnt_r;
    mctl.ovf       = ovf_r;
    mctl.stub_addr = addr_r;
    mctl.stub_bend = bend_r;
    mctl.stub_z    = z_r;
  end

  always_comb begin
    state_nxt  = state_r;
    m_nxt      = m_r;
    slot_nxt   = slot_r;
    k_nxt      = k_r;
    two_s_nxt  = two_s_r;
    side_nxt   = side_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    hwm_nxt    = hwm_r;
    base_nxt   = base_r;
    id_vld_nxt = id_vld_r;
    st_vld_nxt = st_vld_r;
    id_wr_en   = 1'b0;
    id_rd_en   = 1'b0;
    id_rd_addr = m_r;
    st_wr_en   = 1'b0;
    st_wr_addr = {m_r, side_r};
    st_wr_data = {ovf_r, cnt_r + 4'd1, hwm_new};
    st_rd_en   = 1'b0;
    st_rd_addr = {m_r, side_r};
    fr_wr_en   = 1'b0;
    fr_wr_addr = {m_r, side_r, w_lo};
    fr_rd_en   = 1'b0;
    fr_rd_addr = {slot_r, ~k_r[2], ~k_r[1:0]};
    out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_chan.opcode)
            OP_LOAD: begin
              if (slot_ok) begin
                id_wr_en = 1'b1;
                id_vld_nxt[in_slot] = 1'b1;
              end
            end
            OP_PACK: begin
              two_s_nxt = (in_chan.module_id >= ID_2S_MIN);
              side_nxt  = two_s_nxt ? (in_chan.stub_z != 5'd0) : (in_chan.stub_z >= PS_SPLIT);
              m_nxt     = '0;
              state_nxt = S_PK_ID;
            end
            OP_READ: begin
              if (slot_ok) begin
                slot_nxt  = in_slot;
                k_nxt     = 3'd0;
                state_nxt = S_RO_HDR;
              end
            end
            default: ;
          endcase
        end
      end

      S_PK_ID: begin
        id_rd_en  = 1'b1;
        state_nxt = S_PK_CMP;
      end

      // one slot id compared per cycle while slots miss; next id read issued on a miss
      S_PK_CMP: begin
        if (id_eff == id_r) begin
          st_rd_en  = 1'b1;
          state_nxt = S_PK_ST;
        end else if (m_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          id_rd_en   = 1'b1;
          id_rd_addr = m_r + 1'b1;
          m_nxt      = m_r + 1'b1;
        end
      end

      S_PK_ST: begin
        cnt_nxt = st_eff[SIDE_ST_W-2 -: CNT_W];
        ovf_nxt = st_eff[SIDE_ST_W-1];
        hwm_nxt = st_eff[HWM_W-1:0];
        if (cnt_nxt >= (two_s_r ? MAX_2S : MAX_PS)) begin
          // full side: flag overflow, drop the stub
          st_wr_en   = 1'b1;
          st_wr_data = {1'b1, cnt_nxt, hwm_nxt};
          if (m_r == SLOT_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            m_nxt     = m_r + 1'b1;
            state_nxt = S_PK_ID;
          end
        end else begin
          base_nxt   = base_calc[7:0];
          fr_rd_en   = 1'b1;
          fr_rd_addr = {m_r, side_r, base_calc[7:6]};
          state_nxt  = S_PK_F0;
        end
      end

      S_PK_F0: begin
        fr_wr_en   = 1'b1;
        fr_wr_addr = {m_r, side_r, w_lo};
        st_wr_en   = 1'b1;
        st_vld_nxt[{m_r, side_r}] = 1'b1;
        if (need_hi) begin
          fr_rd_en   = 1'b1;
          fr_rd_addr = {m_r, side_r, w_hi};
          state_nxt  = S_PK_F1;
        end else if (m_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          m_nxt     = m_r + 1'b1;
          state_nxt = S_PK_ID;
        end
      end

      S_PK_F1: begin
        fr_wr_en   = 1'b1;
        fr_wr_addr = {m_r, side_r, w_hi};
        if (m_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          m_nxt     = m_r + 1'b1;
          state_nxt = S_PK_ID;
        end
      end

      S_RO_HDR: begin
        id_rd_en   = 1'b1;
        id_rd_addr = slot_r;
        st_rd_en   = 1'b1;
        st_rd_addr = {slot_r, ~k_r[2]};
        state_nxt  = S_RO_HDRL;
      end

      S_RO_HDRL: begin
        two_s_nxt = (id_eff >= ID_2S_MIN);
        cnt_nxt   = st_eff[SIDE_ST_W-2 -: CNT_W];
        ovf_nxt   = st_eff[SIDE_ST_W-1];
        hwm_nxt   = st_eff[HWM_W-1:0];
        state_nxt = S_RO_RD;
      end

      S_RO_RD: begin
        if (out_free) begin
          fr_rd_en  = 1'b1;
          state_nxt = S_RO_OUT;
        end
      end

      S_RO_OUT: begin
        out_load = 1'b1;
        k_nxt    = k_r + 3'd1;
        if (k_r == 3'd7) begin
          st_vld_nxt[{slot_r, 1'b0}] = 1'b0;
          st_vld_nxt[{slot_r, 1'b1}] = 1'b0;
          state_nxt = S_IDLE;
        end else if (k_r == 3'd3) begin
          state_nxt = S_RO_HDR;
        end else begin
          state_nxt = S_RO_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      id_vld_r    <= '0;
      st_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      id_vld_r <= id_vld_nxt;
      st_vld_r <= st_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    slot_r  <= slot_nxt;
    k_r     <= k_nxt;
    two_s_r <= two_s_nxt;
    side_r  <= side_nxt;
    cnt_r   <= cnt_nxt;
    ovf_r   <= ovf_nxt;
    hwm_r   <= hwm_nxt;
    base_r  <= base_nxt;
    if (in_acc) begin
      id_r   <= in_chan.module_id;
      addr_r <= in_chan.stub_address;
      bend_r <= in_chan.stub_bend;
      z_r    <= in_chan.stub_z;
    end
    if (id_rd_en) begin
      id_vld_q_r <= id_vld_r[id_rd_addr];
    end
    if (st_rd_en) begin
      st_vld_q_r <= st_vld_r[st_rd_addr];
    end
    if (out_load) begin
      out_word_r <= fr_wr_data;
      out_idx_r  <= k_r;
      out_last_r <= (k_r == 3'd7);
    end
  end

  scfp_ram #(.WIDTH(ID_W), .DEPTH(NUM_SLOTS)) u_id_ram (
    .clk     (clk),
    .wr_en   (id_wr_en),
    .wr_addr (in_slot),
    .wr_data (in_chan.module_id),
    .rd_en   (id_rd_en),
    .rd_addr (id_rd_addr),
    .rd_data (id_rd_data)
  );

  scfp_ram #(.WIDTH(SIDE_ST_W), .DEPTH(SIDE_DEPTH)) u_side_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  scfp_ram #(.WIDTH(WORD_W), .DEPTH(FRM_DEPTH)) u_frame_ram (
    .clk     (clk),
    .wr_en   (fr_wr_en),
    .wr_addr (fr_wr_addr),
    .wr_data (fr_wr_data),
    .rd_en   (fr_rd_en),
    .rd_addr (fr_rd_addr),
    .rd_data (fr_rd_data)
  );

  scfp_merge u_merge (
    .ctl      (mctl),
    .old_word (fr_rd_data),
    .new_word (fr_wr_data)
  );

  assign out_chan.valid      = out_valid_r;
  assign out_chan.frame_word = out_word_r;
  assign out_chan.word_index = out_idx_r;
  assign out_chan.last       = out_last_r;
endmodule

@@ sv/scfp_chk.sv @@
// Port-level checks of the frame packer, bound to the top level.
module scfp_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [scfp_pkg::OP_W-1:0]     in_opcode,
  input logic [scfp_pkg::SLOT_W-1:0]   in_slot,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [scfp_pkg::WORD_W-1:0]   out_frame_word,
  input logic                          out_last
);
  import scfp_pkg::*;

  // a readout word other than the last one means the readout is still running
  a_busy_mid_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input ready while a readout is still in progress");

  a_pack_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_PACK) |=> !in_ready)
    else $error("ready right after a pack word was taken");

  a_bad_slot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_READ && in_slot >= NUM_SLOTS) |=>
      (in_ready && !($rose(out_valid))))
    else $error("out-of-range readout was not ignored");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_frame_word)))
    else $error("stalled output word changed");
endmodule

bind stub_concentrator_frame_packer scfp_chk u_scfp_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_opcode      (in_chan.opcode),
  .in_slot        (in_chan.slot),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_frame_word (out_chan.frame_word),
  .out_last       (out_chan.last)
);

@@ test/tb.sv @@
// Self-checking bench for the stub concentrator frame packer: directed and sequenced random words.
module tb;
  import scfp_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int TAIL_WORDS    = 40;
  localparam int RANDOM_WORDS  = 330;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int SIDE_LEFT     = 0;
  localparam int SIDE_RIGHT    = 1;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [BEND_W-1:0] bend;
    logic [Z_W-1:0]    z;
    bit                drain_first;
  } stub_word_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [WIDX_W-1:0] idx;
    logic              last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst_n;

  scfp_in_if  in_chan();
  scfp_out_if out_chan();

  stub_concentrator_frame_packer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stub_word_t  stub_words_pending[$];
  frame_word_t frame_words_due[$];

  // Shadow copy of the slot table and frame memory
  logic [ID_W-1:0]  slot_id_tbl [NUM_SLOTS];
  logic [255:0]     frame_img   [NUM_SLOTS][2];
  logic [CNT_W-1:0] fill_cnt    [NUM_SLOTS][2];
  logic             ovf_flag    [NUM_SLOTS][2];

  int   errors = 0;
  int   words_taken = 0;
  int   tx_gap = 0;
  int   rx_hold = 0;
  int   long_left = 0;
  int   cycles = 0;
  bit   long_hold_done = 1'b0;
  logic due_empty;
  logic tail_phase;

  function automatic bit is_two_s(input logic [ID_W-1:0] id);
    return (int'(id) / LAYER_DIV) > LAYER_2S_ABOVE;
  endfunction

  function automatic void add_word(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                   input logic [ID_W-1:0] id, input logic [ADDR_W-1:0] addr,
                                   input logic [BEND_W-1:0] bend, input logic [Z_W-1:0] z,
                                   input bit drain_first);
    stub_word_t w;
    w.op = op;
    w.slot = slot;
    w.id = id;
    w.addr = addr;
    w.bend = bend;
    w.z = z;
    w.drain_first = drain_first;
    stub_words_pending.push_back(w);
  endfunction

  task automatic apply_stub_word(input stub_word_t w);
    logic [255:0] f;
    frame_word_t  r;
    bit           two_s;
    int           side, limit, size, base, m, k, sd, sl;
    case (w.op)
      OP_LOAD: begin
        if (w.slot < NUM_SLOTS) slot_id_tbl[w.slot] = w.id;
      end
      OP_PACK: begin
        two_s = is_two_s(w.id);
        if (two_s) begin
          side = (w.z < 1) ? SIDE_LEFT : SIDE_RIGHT;
          limit = int'(MAX_2S);
          size = int'(SIZE_2S);
        end else begin
          side = (w.z < PS_SPLIT) ? SIDE_LEFT : SIDE_RIGHT;
          limit = int'(MAX_PS);
          size = int'(SIZE_PS);
        end
        for (m = 0; m < NUM_SLOTS; m++) begin
          if (slot_id_tbl[m] == w.id) begin
            if (fill_cnt[m][side] >= limit) begin
              ovf_flag[m][side] = 1'b1;
            end else begin
              f = frame_img[m][side];
              base = HDR_BITS + int'(fill_cnt[m][side]) * size;
              f[base +: 19] = {w.bend, w.addr, 3'b000};
              if (!two_s) f[base + 19 +: 4] = w.z[3:0];
              frame_img[m][side] = f;
              fill_cnt[m][side] = fill_cnt[m][side] + 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        if (w.slot < NUM_SLOTS) begin
          for (sd = 0; sd < 2; sd++) begin
            f = frame_img[w.slot][sd];
            f[25:0] = '0;
            f[0] = !is_two_s(slot_id_tbl[w.slot]);
            f[9] = ovf_flag[w.slot][sd];
            f[25:22] = fill_cnt[w.slot][sd];
            frame_img[w.slot][sd] = f;
          end
          // right frame first, high slice first
          for (k = 0; k < 8; k++) begin
            sd = (k < 4) ? SIDE_RIGHT : SIDE_LEFT;
            sl = 3 - (k % 4);
            f = frame_img[w.slot][sd];
            r.word = f[sl * 64 +: 64];
            r.idx = WIDX_W'(k);
            r.last = (k == 7);
            frame_words_due.push_back(r);
          end
          for (sd = 0; sd < 2; sd++) begin
            frame_img[w.slot][sd] = '0;
            fill_cnt[w.slot][sd] = '0;
            ovf_flag[w.slot][sd] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Driver: offers the oldest pending word, holds valid until taken
  always @(posedge clk) begin : drive
    bit fire;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      tail_phase <= 1'b0;
    end else begin
      fire = in_chan.valid && in_chan.ready;
      if (fire) stub_words_pending.pop_front();
      tail_phase <= (stub_words_pending.size() <= TAIL_WORDS);
      if (!in_chan.valid || fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_chan.valid <= 1'b0;
        end else if (stub_words_pending.size() == 0) begin
          in_chan.valid <= 1'b0;
        end else if (stub_words_pending[0].drain_first && (fire || !due_empty)) begin
          in_chan.valid <= 1'b0;
        end else if (stub_words_pending.size() > TAIL_WORDS && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(0, 14);
          in_chan.valid <= 1'b0;
        end else begin
          in_chan.valid <= 1'b1;
          in_chan.opcode <= stub_words_pending[0].op;
          in_chan.slot <= stub_words_pending[0].slot;
          in_chan.module_id <= stub_words_pending[0].id;
          in_chan.stub_address <= stub_words_pending[0].addr;
          in_chan.stub_bend <= stub_words_pending[0].bend;
          in_chan.stub_z <= stub_words_pending[0].z;
        end
      end
    end
  end

  // one long receiver stall to back the block up into its input
  always @(posedge clk) begin : long_stall
    if (!rst_n) begin
      long_left <= 0;
    end else if (!long_hold_done && words_taken >= 32) begin
      long_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
    end
  end

  // Monitor: predicts on every accepted input word, checks every accepted frame word
  always @(posedge clk) begin : watch
    stub_word_t  seen;
    frame_word_t due;
    int          m;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      due_empty <= 1'b1;
      frame_words_due.delete();
      for (m = 0; m < NUM_SLOTS; m++) begin
        slot_id_tbl[m] = '0;
        frame_img[m][0] = '0;
        frame_img[m][1] = '0;
        fill_cnt[m][0] = '0;
        fill_cnt[m][1] = '0;
        ovf_flag[m][0] = 1'b0;
        ovf_flag[m][1] = 1'b0;
      end
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        seen.op = in_chan.opcode;
        seen.slot = in_chan.slot;
        seen.id = in_chan.module_id;
        seen.addr = in_chan.stub_address;
        seen.bend = in_chan.stub_bend;
        seen.z = in_chan.stub_z;
        seen.drain_first = 1'b0;
        apply_stub_word(seen);
      end
      if (out_chan.valid && out_chan.ready) begin
        words_taken++;
        if (frame_words_due.size() == 0) begin
          if (errors < 10)
            $display("unexpected frame word %h idx %0d last %0b",
                     out_chan.frame_word, out_chan.word_index, out_chan.last);
          errors++;
        end else begin
          due = frame_words_due.pop_front();
          if (out_chan.frame_word !== due.word || out_chan.word_index !== due.idx ||
              out_chan.last !== due.last) begin
            if (errors < 10)
              $display("frame word: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                       due.word, due.idx, due.last,
                       out_chan.frame_word, out_chan.word_index, out_chan.last);
            errors++;
          end
        end
      end
      due_empty <= (frame_words_due.size() == 0);
      if (long_left > 0) begin
        out_chan.ready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold--;
        out_chan.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        rx_hold = $urandom_range(0, 14);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("stub_concentrator_frame_packer: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   alt_id;
    logic [SLOT_W-1:0] sl [3];
    logic [Z_W-1:0]    z;
    bit                two_s, drained, drain_now;
    int                deep, nsl, npk, fav, side, pick, i, j;

    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.opcode = OP_LOAD;
    in_chan.slot = '0;
    in_chan.module_id = '0;
    in_chan.stub_address = '0;
    in_chan.stub_bend = '0;
    in_chan.stub_z = '0;
    out_chan.ready = 1'b0;

    // empty slot: PS header with nothing else
    add_word(OP_READ, 6'd0, 18'd0, 11'd0, 5'h00, 5'd0, 1'b0);
    add_word(OP_LOAD, 6'd0, 18'd80000, 11'd0, 5'h00, 5'd0, 1'b0);
    add_word(OP_LOAD, 6'd5, 18'd80000, 11'd0, 5'h00, 5'd0, 1'b0);
    add_word(OP_LOAD, 6'd39, 18'd79999, 11'd0, 5'h00, 5'd0, 1'b0);
    // out-of-range slots are ignored
    add_word(OP_LOAD, 6'd63, 18'd262143, 11'h7FF, 5'h1F, 5'd31, 1'b0);
    add_word(OP_LOAD, 6'd40, 18'd262143, 11'h7FF, 5'h1F, 5'd31, 1'b0);
    // 2S into two matching slots: z 0 left, others right
    add_word(OP_PACK, 6'd0, 18'd80000, 11'h7FF, 5'h10, 5'd0, 1'b0);
    add_word(OP_PACK, 6'd0, 18'd80000, 11'h000, 5'h0F, 5'd31, 1'b0);
    add_word(OP_PACK, 6'd63, 18'd80000, 11'h555, 5'h1F, 5'd1, 1'b0);
    // PS split at z 16
    add_word(OP_PACK, 6'd0, 18'd79999, 11'h7FF, 5'h1F, 5'd15, 1'b0);
    add_word(OP_PACK, 6'd0, 18'd79999, 11'h000, 5'h00, 5'd16, 1'b0);
    add_word(OP_PACK, 6'd0, 18'd79999, 11'h001, 5'h0F, 5'd31, 1'b0);
    // no slot holds this id
    add_word(OP_PACK, 6'd63, 18'd262143, 11'h2AA, 5'h0A, 5'd9, 1'b0);
    add_word(OP_NONE, 6'd63, 18'd262143, 11'h7FF, 5'h1F, 5'd31, 1'b0);
    // busy slot reloaded with a PS id: header type follows the new id
    add_word(OP_LOAD, 6'd0, 18'd1234, 11'd0, 5'h00, 5'd0, 1'b0);
    add_word(OP_READ, 6'd0, 18'd0, 11'd0, 5'h00, 5'd0, 1'b0);
    add_word(OP_READ, 6'd5, 18'd0, 11'd0, 5'h00, 5'd0, 1'b0);
    add_word(OP_READ, 6'd39, 18'd0, 11'd0, 5'h00, 5'd0, 1'b0);
    add_word(OP_READ, 6'd63, 18'd0, 11'd0, 5'h00, 5'd0, 1'b0);
    add_word(OP_READ, 6'd40, 18'd0, 11'd0, 5'h00, 5'd0, 1'b0);
    // id 0 matches every slot never loaded
    add_word(OP_PACK, 6'd0, 18'd0, 11'h005, 5'h03, 5'd7, 1'b0);
    add_word(OP_READ, 6'd1, 18'd0, 11'd0, 5'h00, 5'd0, 1'b0);
    add_word(OP_READ, 6'd39, 18'd0, 11'd0, 5'h00, 5'd0, 1'b0);

    // random part: load one to three slots, burst stubs at them, in most rounds read them back
    deep = 0;
    drained = 1'b0;
    while (deep < RANDOM_WORDS) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) id = 18'd79999;
      else if (pick == 1) id = 18'd80000;
      else if (pick == 2) id = 18'd262143;
      else if (pick == 3) id = 18'd0;
      else if (pick < 8) id = ID_W'($urandom_range(0, 79999));
      else id = ID_W'($urandom_range(80000, 262143));
      two_s = is_two_s(id);
      alt_id = two_s ? ID_W'($urandom_range(0, 79999)) : ID_W'($urandom_range(80000, 262143));
      drain_now = (deep >= RANDOM_WORDS / 2) && !drained;
      if (drain_now) drained = 1'b1;

      nsl = $urandom_range(1, 3);
      for (i = 0; i < nsl; i++) begin
        sl[i] = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        add_word(OP_LOAD, sl[i], id, ADDR_W'($urandom), BEND_W'($urandom), Z_W'($urandom),
                 drain_now && i == 0);
      end
      npk = ($urandom_range(0, 2) == 0) ? $urandom_range(14, 28) : $urandom_range(1, 10);
      fav = $urandom_range(0, 1);
      for (j = 0; j < npk; j++) begin
        side = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : fav;
        if (two_s) z = (side == SIDE_LEFT) ? 5'd0 : Z_W'($urandom_range(1, 31));
        else z = (side == SIDE_LEFT) ? Z_W'($urandom_range(0, 15)) : Z_W'($urandom_range(16, 31));
        if (j == npk / 2 && $urandom_range(0, 4) == 0) begin
          add_word(OP_LOAD, sl[0], alt_id, ADDR_W'($urandom), BEND_W'($urandom),
                   Z_W'($urandom), 1'b0);
          deep++;
        end
        add_word(OP_PACK, SLOT_W'($urandom), id, ADDR_W'($urandom), BEND_W'($urandom), z,
                 1'b0);
      end
      deep += nsl + npk;
      if ($urandom_range(0, 4) != 0) begin
        for (i = nsl - 1; i >= 0; i--) add_word(OP_READ, sl[i], ID_W'($urandom),
                                                ADDR_W'($urandom), BEND_W'($urandom),
                                                Z_W'($urandom), 1'b0);
        deep += nsl;
      end
      repeat ($urandom_range(0, 2))
        add_word(OP_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 63)), ID_W'($urandom),
                 ADDR_W'($urandom), BEND_W'($urandom), Z_W'($urandom), 1'b0);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(posedge clk);
      #1;
    end while (stub_words_pending.size() != 0 || in_chan.valid || !due_empty);
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;
    if (frame_words_due.size() != 0) begin
      if (errors < 10) $display("%0d frame words never arrived", frame_words_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("stub_concentrator_frame_packer: match");
    end else begin
      $display("stub_concentrator_frame_packer: mismatch");
    end
    $finish;
  end

endmodule
